>>> design/duplicate_packet_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Duplicate packet filter assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_PACKET_FILTER_TOP_ASSERT_SVH
`define DUPLICATE_PACKET_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/dpf_pkg.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter package
// Shared types for the duplicate packet filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } dpf_state_e;

endpackage

>>> design/dpf_front.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter front end
// Accepts words, folds the source onto the table range and queues them.
// ----------------------------------------------------------------------------
module dpf_front #(
  parameter int unsigned MAX_SOURCES = 256,
  parameter int unsigned SEQ_BITS    = 32,
  parameter int unsigned SRC_W       = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                hold_i,
  input  logic [7:0]          source_id_i,
  input  logic [31:0]         seq_number_i,
  output logic                busy_o,
  output logic                head_valid_o,
  output logic [SRC_W-1:0]    head_src_o,
  output logic [SEQ_BITS-1:0] head_seq_o,
  input  logic                pop_i
);

  logic [1:0]          cnt_q, cnt_d;
  logic                wr_ptr_q, rd_ptr_q;
  logic [SRC_W-1:0]    q_src_q [2];
  logic [SEQ_BITS-1:0] q_seq_q [2];
  logic [SRC_W-1:0]    src_map [256];
  logic                push, pop;

  for (genvar i = 0; i < 256; i++) begin : g_map
    localparam int unsigned SrcMod = i % MAX_SOURCES;
    assign src_map[i] = SRC_W'(SrcMod);
  end

  assign busy_o       = hold_i | (cnt_q == 2'd2);
  assign push         = start_i & ~busy_o;
  assign pop          = pop_i & (cnt_q != 2'd0);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_src_o   = q_src_q[rd_ptr_q];
  assign head_seq_o   = q_seq_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_src_q[wr_ptr_q] <= src_map[source_id_i];
      q_seq_q[wr_ptr_q] <= seq_number_i[SEQ_BITS-1:0];
    end
  end

endmodule

>>> design/dpf_back.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter back end
// Reads a source's history row, checks for a match and writes the row back when there is none.
// ----------------------------------------------------------------------------
module dpf_back #(
  parameter int unsigned MAX_SOURCES   = 256,
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned SEQ_BITS      = 32,
  parameter int unsigned SRC_W         = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  logic [SRC_W-1:0]    head_src_i,
  input  logic [SEQ_BITS-1:0] head_seq_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                done_o,
  output logic                is_new_o
);
  import dpf_pkg::*;

  localparam int unsigned SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ENT_W   = HISTORY_DEPTH * SEQ_BITS;
  localparam int unsigned ROW_W   = ENT_W + CNT_W + SLOT_W;
  localparam logic [SRC_W-1:0]  LastSrc  = SRC_W'(MAX_SOURCES - 1);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(HISTORY_DEPTH);

  dpf_state_e state_q, state_d;

  logic [ROW_W-1:0]    mem_q [MAX_SOURCES];
  logic [ROW_W-1:0]    rd_row_q;
  logic [SRC_W-1:0]    src_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [SRC_W-1:0]    clr_q, clr_d;
  logic                done_q, done_d;
  logic                is_new_q, is_new_d;

  logic [ENT_W-1:0]    entries, new_entries;
  logic [CNT_W-1:0]    cnt, cnt_new;
  logic [SLOT_W-1:0]   old, old_new, wr_slot;
  logic                hit, full;
  logic                rd_en, wr_en;
  logic [SRC_W-1:0]    wr_addr;
  logic [ROW_W-1:0]    wr_row;

  assign entries = rd_row_q[ENT_W-1:0];
  assign cnt     = rd_row_q[ENT_W +: CNT_W];
  assign old     = rd_row_q[ENT_W + CNT_W +: SLOT_W];
  assign full    = (cnt == FullCnt);
  assign wr_slot = full ? old : cnt[SLOT_W-1:0];
  assign cnt_new = full ? cnt : cnt + CNT_W'(1);

  always_comb begin
    old_new = old;
    if (full) begin
      old_new = (old == LastSlot) ? '0 : old + SLOT_W'(1);
    end
  end

  always_comb begin
    hit         = 1'b0;
    new_entries = entries;
    for (int e = 0; e < HISTORY_DEPTH; e++) begin
      if ((CNT_W'(e) < cnt) && (entries[e*SEQ_BITS +: SEQ_BITS] == seq_q)) begin
        hit = 1'b1;
      end
      if (SLOT_W'(e) == wr_slot) begin
        new_entries[e*SEQ_BITS +: SEQ_BITS] = seq_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastSrc) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = src_q;
    wr_row   = {old_new, cnt_new, new_entries};
    clr_d    = clr_q;
    done_d   = 1'b0;
    is_new_d = is_new_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = '0;
        clr_d   = clr_q + SRC_W'(1);
      end
      ST_IDLE: begin
        rd_en = head_valid_i;
      end
      ST_EVAL: begin
        wr_en    = ~hit;
        done_d   = 1'b1;
        is_new_d = ~hit;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign pop_o      = rd_en;
  assign clearing_o = (state_q == ST_CLEAR);
  assign done_o     = done_q;
  assign is_new_o   = is_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_new_q <= is_new_d;
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[head_src_i];
      src_q    <= head_src_i;
      seq_q    <= head_seq_i;
    end
  end

endmodule

>>> design/duplicate_packet_filter_top.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter
// Flags packets whose sequence number is already in the source's history.
// ----------------------------------------------------------------------------
// A word (source_id_i, seq_number_i) is taken at a rising edge where start_i
// is high and busy_o is low. Each word yields one result: done_o is high for
// exactly one cycle with is_new_o valid, and the receiver cannot stall it.
// A two-word queue sits between the accepting front end and the history
// engine, so an idle block takes up to three words back to back.
// From an idle block an accepted word goes into the queue, its history row
// is then read into a register while the engine moves to its evaluate state,
// and done_o is driven from a register. For each word the engine first reads
// the source's history row, then compares it and, for a new word, writes
// the row back; the queue still takes words, while it has room, meanwhile.
// After reset the engine empties every history row, one row per cycle;
// busy_o stays high during this pass.
// A source_id_i at or above MAX_SOURCES is folded modulo MAX_SOURCES, and
// only the low SEQ_BITS bits of seq_number_i are compared and stored.
// ----------------------------------------------------------------------------
module duplicate_packet_filter_top #(
  parameter int unsigned MAX_SOURCES   = 256,
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned SEQ_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  source_id_i,
  input  logic [31:0] seq_number_i,
  output logic        done_o,
  output logic        is_new_o
);

  localparam int unsigned SRC_W = $clog2(MAX_SOURCES);

  logic                head_valid;
  logic [SRC_W-1:0]    head_src;
  logic [SEQ_BITS-1:0] head_seq;
  logic                pop;
  logic                clearing;

  dpf_front #(
    .MAX_SOURCES (MAX_SOURCES),
    .SEQ_BITS    (SEQ_BITS),
    .SRC_W       (SRC_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .hold_i       (clearing),
    .source_id_i  (source_id_i),
    .seq_number_i (seq_number_i),
    .busy_o       (busy_o),
    .head_valid_o (head_valid),
    .head_src_o   (head_src),
    .head_seq_o   (head_seq),
    .pop_i        (pop)
  );

  dpf_back #(
    .MAX_SOURCES   (MAX_SOURCES),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SEQ_BITS      (SEQ_BITS),
    .SRC_W         (SRC_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_src_i   (head_src),
    .head_seq_i   (head_seq),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .is_new_o     (is_new_o)
  );

endmodule

>>> design/dpf_checker.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "duplicate_packet_filter_top_assert.svh"

module dpf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic done_o
);

  // The engine reads and then evaluates each word in separate states, so results never come back to back.
  `DPF_ASSERT_NEXT(a_done_spaced, done_o, !done_o)

  // The history clearing pass keeps the block busy right after reset.
  `DPF_ASSERT_NOW(a_busy_after_reset, $rose(rst_ni), busy_o)

  // No result can be pending when reset releases.
  `DPF_ASSERT_NOW(a_no_done_after_reset, $rose(rst_ni), !done_o)

endmodule

bind duplicate_packet_filter_top dpf_checker u_dpf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .busy_o (busy_o),
  .done_o (done_o)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Duplicate packet filter testbench
// Sends (source, sequence number) words through the start/busy handshake,
// keeps its own per-source history of recent sequence numbers to predict
// whether each word is new or a duplicate, and checks every done_o strobe
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_SOURCES  = 256;
  localparam int unsigned DEPTH        = 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned IDLE_PERCENT = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  source_id_i;
  logic [31:0] seq_number_i;
  logic        done_o;
  logic        is_new_o;

  logic [31:0] seen_seq [NUM_SOURCES][DEPTH];
  logic [3:0]  seen_count [NUM_SOURCES];
  logic [2:0]  ring_oldest [NUM_SOURCES];

  logic        expected_is_new [$];
  int unsigned error_count;
  int unsigned stall_cycles;

  duplicate_packet_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .source_id_i  (source_id_i),
    .seq_number_i (seq_number_i),
    .done_o       (done_o),
    .is_new_o     (is_new_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic predict_is_new(input logic [7:0] src, input logic [31:0] seq);
    int unsigned filled;
    int unsigned slot;
    filled = seen_count[src];
    if (filled > DEPTH) filled = DEPTH;
    for (slot = 0; slot < filled; slot++) begin
      if (seen_seq[src][slot] == seq) return 1'b0;
    end
    if (filled < DEPTH) begin
      seen_seq[src][filled] = seq;
      seen_count[src] = 4'(filled + 1);
    end else begin
      seen_seq[src][ring_oldest[src]] = seq;
      ring_oldest[src] = (ring_oldest[src] == 3'(DEPTH - 1)) ? 3'd0 : ring_oldest[src] + 3'd1;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input logic [7:0] src, input logic [31:0] seq);
    @(negedge clk_i);
    start_i      <= 1'b1;
    source_id_i  <= src;
    seq_number_i <= seq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_is_new.push_back(predict_is_new(src, seq));
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_is_new.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of both fields, duplicates across and within sources, and a
  // history that fills, wraps and forgets its oldest entry.
  task automatic test_directed();
    int unsigned i;
    send_word(8'd0, 32'd0);
    send_word(8'd0, 32'd0);
    send_word(8'd255, 32'hFFFF_FFFF);
    send_word(8'd255, 32'hFFFF_FFFF);
    send_word(8'd0, 32'hFFFF_FFFF);
    send_word(8'd255, 32'd0);
    for (i = 0; i < DEPTH; i++) send_word(8'h5A, 32'd100 + i);
    send_word(8'h5A, 32'd108);
    send_word(8'h5A, 32'd100);
    send_word(8'h5A, 32'd102);
    send_word(8'h5A, 32'd101);
  endtask

  // The sender stops until every pending result is back, then resumes.
  task automatic test_pause_until_drained();
    int unsigned i;
    for (i = 0; i < 10; i++) send_word(8'hA5, 32'h5555_5550 + $urandom_range(0, 5));
    wait_for_results();
    for (i = 0; i < 10; i++) send_word(8'hA5, 32'h5555_5550 + $urandom_range(0, 5));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input bit allow_idle);
    logic [7:0]  hot_src [4];
    logic [31:0] seq_base;
    logic [7:0]  src;
    logic [31:0] seq;
    int unsigned roll;
    int unsigned i;
    for (i = 0; i < 4; i++) hot_src[i] = 8'($urandom_range(0, NUM_SOURCES - 1));
    seq_base = $urandom;
    for (i = 0; i < n_words; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        src = hot_src[$urandom_range(0, 3)];
        seq = seq_base + $urandom_range(0, 11);
      end else if (roll < 75) begin
        src = 8'($urandom_range(0, NUM_SOURCES - 1));
        seq = seq_base + $urandom_range(0, 11);
      end else if (roll < 90) begin
        src = hot_src[$urandom_range(0, 3)];
        seq = $urandom;
      end else begin
        src = 8'($urandom_range(0, NUM_SOURCES - 1));
        seq = $urandom;
      end
      if ($urandom_range(0, 9) == 0) seq_base = seq_base + $urandom_range(1, 3);
      if ($urandom_range(0, 199) == 0) hot_src[$urandom_range(0, 3)] = 8'($urandom);
      if (allow_idle && $urandom_range(0, 99) < IDLE_PERCENT) hold_off($urandom_range(1, 4));
      send_word(src, seq);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_is_new.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_new %0b", $time, is_new_o);
        error_count++;
      end else if (is_new_o !== expected_is_new[0]) begin
        $display("%0t: is_new mismatch, expected %0b, actual %0b",
                 $time, expected_is_new[0], is_new_o);
        error_count++;
        void'(expected_is_new.pop_front());
      end else begin
        void'(expected_is_new.pop_front());
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if (done_o === 1'b1 || (start_i && busy_o === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: timeout, no word or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned s;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    source_id_i  = 8'd0;
    seq_number_i = 32'd0;
    error_count  = 0;
    for (s = 0; s < NUM_SOURCES; s++) begin
      seen_count[s]  = 4'd0;
      ring_oldest[s] = 3'd0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_pause_until_drained();
    test_random_traffic(300, 1'b0);
    test_random_traffic(1600, 1'b1);

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
